### sv/rsq_pkg.sv
// Shared constants, types and the exponential lookup table for the row softmax block.
package rsq_pkg;

  localparam int unsigned INV_W      = 16;
  localparam int unsigned OSC_W      = 15;
  localparam int unsigned PROB_W     = 15;
  localparam int unsigned EXP_W      = 16;
  localparam int unsigned M_W        = 13;
  localparam int unsigned M_LIMIT    = 4096;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned INV_RESET  = 4096;
  localparam int unsigned OSC_RESET  = 127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_IN_SCALE = 1'b0,
    CFG_OUT_SCALE    = 1'b1
  } cfg_idx_e;

  typedef logic [40:0] q40_t;
  typedef q40_t exp_tab_t [256];

  // unsigned quotient by shift and subtract, for elaboration-time tables
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-j/256) in Q40 by a 24-term series, positive and negative terms apart
  function automatic q40_t exp_frac_q40(input int unsigned j);
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    pos  = 64'd1 << 40;
    neg  = 64'd0;
    term = pos;
    for (int unsigned n = 1; n <= 24; n++) begin
      term = udiv64(term * j, 64'(256 * n));
      if ((n & 1) == 1) neg += term;
      else              pos += term;
    end
    return q40_t'(pos - neg);
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    for (int unsigned j = 0; j < 256; j++) tab[j] = exp_frac_q40(j);
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB     = build_exp_tab();
  localparam q40_t     EXP_NEG_ONE = exp_frac_q40(256);

endpackage

### sv/rsq_if.sv
// Stream interfaces for the row softmax input and result channels.
interface rsq_in_if #(parameter int VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          row_end;
  modport source (output valid, value, row_end, input ready);
  modport sink   (input valid, value, row_end, output ready);
endinterface

interface rsq_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] prob;
  logic        last_of_row;
  logic        overflow;
  modport source (output valid, prob, last_of_row, overflow, input ready);
  modport sink   (input valid, prob, last_of_row, overflow, output ready);
endinterface

### sv/rsq_exp_unit.sv
// Iterative Q15 exponential: table lookup, then repeated Q40 multiplies on one shared multiplier.
module rsq_exp_unit
  import rsq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [M_W-1:0]   m_i,
  output logic             done_o,
  output logic [EXP_W-1:0] e_o
);

  localparam logic [1:0] ES_IDLE  = 2'd0;
  localparam logic [1:0] ES_MUL   = 2'd1;
  localparam logic [1:0] ES_ROUND = 2'd2;

  localparam logic [19:0] BH = EXP_NEG_ONE[39:20];
  localparam logic [19:0] BL = EXP_NEG_ONE[19:0];

  logic [1:0]       state_q, state_d;
  logic [1:0]       ph_q, ph_d;
  logic [4:0]       k_q, k_d;
  q40_t             v_q, v_d;
  logic [61:0]      acc_q, acc_d;
  logic             done_q, done_d;
  logic [EXP_W-1:0] e_q, e_d;
  logic [20:0]      mul_a;
  logic [19:0]      mul_b;
  logic [40:0]      prod;
  logic [61:0]      acc_fin;

  // phase 0: ah*bh, 1: al*bh, 2: ah*bl, 3: al*bl
  assign mul_a   = ph_q[0] ? {1'b0, v_q[19:0]} : v_q[40:20];
  assign mul_b   = ph_q[1] ? BL : BH;
  assign prod    = mul_a * mul_b;
  assign acc_fin = acc_q + 62'(prod >> 20);

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    k_d     = k_q;
    v_d     = v_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    e_d     = e_q;
    case (state_q)
      ES_IDLE: begin
        if (start_i) begin
          v_d     = EXP_TAB[m_i[7:0]];
          k_d     = m_i[12:8];
          ph_d    = 2'd0;
          state_d = (m_i[12:8] == 5'd0) ? ES_ROUND : ES_MUL;
        end
      end
      ES_MUL: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0:    acc_d = {1'b0, prod, 20'd0};
          2'd1,
          2'd2:    acc_d = acc_q + 62'(prod);
          default: begin
            v_d = q40_t'(acc_fin >> 20);
            k_d = k_q - 5'd1;
            if (k_q == 5'd1) state_d = ES_ROUND;
          end
        endcase
      end
      ES_ROUND: begin
        e_d     = EXP_W'((v_q + 41'(1 << 24)) >> 25);
        done_d  = 1'b1;
        state_d = ES_IDLE;
      end
      default: state_d = ES_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= ph_d;
    k_q   <= k_d;
    v_q   <= v_d;
    acc_q <= acc_d;
    e_q   <= e_d;
  end

  assign done_o = done_q;
  assign e_o    = e_q;

endmodule

### sv/rsq_div_unit.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit Q_W bits.
module rsq_div_unit
  import rsq_pkg::*;
#(
  parameter int NUM_W = 33,
  parameter int DEN_W = 23,
  parameter int Q_W   = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quo_o
);

  localparam int SH_W  = DEN_W + Q_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = $clog2(Q_W);

  logic             busy_q, done_q, zero_q;
  logic [NUM_W-1:0] r_q;
  logic [SH_W-1:0]  d_q;
  logic [Q_W-1:0]   q_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ge;

  assign ge = CMP_W'(r_q) >= CMP_W'(d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CNT_W'(Q_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= num_i;
      d_q    <= SH_W'(den_i) << (Q_W - 1);
      zero_q <= (den_i == '0);
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (ge) r_q <= NUM_W'(CMP_W'(r_q) - CMP_W'(d_q));
      q_q   <= {q_q[Q_W-2:0], ge};
      d_q   <= d_q >> 1;
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : q_q;

endmodule

### sv/row_softmax_quantized.sv
// Row softmax top level: row buffer, exponential pass, division pass and result register.
// Throughput: while a row streams in, one element is taken per cycle.
// After the row-end transaction each element gets a table lookup and k Q40 multiplies in the
// exponential pass (k = integer part of the scaled distance, 0..16; zero weight past the
// zero cutoff), then a division on the bit-serial divider plus the result handshake.
// Reset: asynchronous active low; returns control, row state and configuration to defaults.
module row_softmax_quantized
  import rsq_pkg::*;
#(
  parameter int ROW_MAX     = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rsq_in_if.sink                in_i,
  rsq_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(ROW_MAX);
  localparam int CW    = $clog2(ROW_MAX + 1);
  localparam int SUM_W = CW + 15;
  localparam int T_W   = VALUE_WIDTH + 1;
  localparam int MF_W  = T_W + INV_W - 4;
  localparam int NUM_W = SUM_W + 32;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXP_RD = 4'd1;
  localparam logic [3:0] S_EXP_M  = 4'd2;
  localparam logic [3:0] S_EXP_E  = 4'd3;
  localparam logic [3:0] S_EXP_W  = 4'd4;
  localparam logic [3:0] S_DIV_RD = 4'd5;
  localparam logic [3:0] S_DIV_GO = 4'd6;
  localparam logic [3:0] S_DIV_W  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [3:0]                    state_q, state_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 count_q, count_d;
  logic signed [VALUE_WIDTH-1:0] max_q, max_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic                          drop_q, drop_d;
  logic [INV_W-1:0]              inv_q;
  logic [OSC_W-1:0]              osc_q;
  logic [MF_W-1:0]               m_q;
  logic                          out_valid_q, out_valid_d;
  logic [PROB_W-1:0]             prob_q;
  logic                          last_q, ovf_q;

  // row and exponential stores
  logic signed [VALUE_WIDTH-1:0] row_mem [ROW_MAX];
  logic [EXP_W-1:0]              exp_mem [ROW_MAX];
  logic signed [VALUE_WIDTH-1:0] row_rd_q;
  logic [EXP_W-1:0]              exp_rd_q;

  logic             in_fire, has_room, last_idx;
  logic             e_we;
  logic [EXP_W-1:0] e_val;
  logic [T_W-1:0]   t_val;
  logic [MF_W-1:0]  m_full;
  logic             exp_start, exp_done;
  logic [EXP_W-1:0] exp_e;
  logic             div_start, div_done;
  logic [31:0]      div_prod;
  logic [NUM_W-1:0] div_num;
  logic [PROB_W-1:0] div_quo;

  assign in_fire  = in_i.valid && in_i.ready;
  assign has_room = count_q < CW'(ROW_MAX);
  assign last_idx = CW'(idx_q) == (count_q - CW'(1));

  // distance below the row max, then scale to 1/256 steps
  assign t_val  = T_W'(max_q) - T_W'(row_rd_q);
  assign m_full = MF_W'((T_W + INV_W)'(t_val) * (T_W + INV_W)'(inv_q) >> 4);

  assign exp_start = (state_q == S_EXP_E) && (m_q <= MF_W'(M_LIMIT));
  assign div_start = (state_q == S_DIV_GO);
  assign div_prod  = 32'({osc_q, 1'b0}) * 32'(exp_rd_q);
  assign div_num   = NUM_W'(div_prod) + NUM_W'(sum_q);

  rsq_exp_unit u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .m_i     (m_q[M_W-1:0]),
    .done_o  (exp_done),
    .e_o     (exp_e)
  );

  rsq_div_unit #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W + 1),
    .Q_W   (PROB_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({sum_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    max_d       = max_q;
    sum_d       = sum_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    e_we        = 1'b0;
    e_val       = exp_e;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (has_room) begin
            count_d = count_q + CW'(1);
            if (in_i.value > max_q) max_d = in_i.value;
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.row_end) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = S_EXP_RD;
          end
        end
      end
      S_EXP_RD: state_d = S_EXP_M;
      S_EXP_M:  state_d = S_EXP_E;
      S_EXP_E: begin
        if (!exp_start) begin
          // too far below the max: weight is zero
          e_we  = 1'b1;
          e_val = '0;
        end else begin
          state_d = S_EXP_W;
        end
      end
      S_EXP_W: e_we = exp_done;
      S_DIV_RD: state_d = S_DIV_GO;
      S_DIV_GO: state_d = S_DIV_W;
      S_DIV_W: begin
        if (div_done) begin
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (last_idx) begin
            count_d = '0;
            max_d   = MOST_NEG;
            sum_d   = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_DIV_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // commit one exponential and advance the pass
    if (e_we) begin
      sum_d = sum_q + SUM_W'(e_val);
      if (last_idx) begin
        idx_d   = '0;
        state_d = S_DIV_RD;
      end else begin
        idx_d   = idx_q + AW'(1);
        state_d = S_EXP_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      max_q       <= MOST_NEG;
      sum_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      inv_q       <= INV_W'(INV_RESET);
      osc_q       <= OSC_W'(OSC_RESET);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INV_IN_SCALE: inv_q <= cfg_data_i[INV_W-1:0];
          CFG_OUT_SCALE:    osc_q <= cfg_data_i[OSC_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  // payload registers: scaled distance and the result held for the sink
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXP_M) m_q <= m_full;
    if (state_q == S_DIV_W && div_done) begin
      prob_q <= div_quo;
      last_q <= last_idx;
      ovf_q  <= drop_q;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (in_fire && has_room) row_mem[count_q[AW-1:0]] <= in_i.value;
    row_rd_q <= row_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (e_we) exp_mem[idx_q] <= e_val;
    exp_rd_q <= exp_mem[idx_q];
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.prob        = prob_q;
  assign out_o.last_of_row = last_q;
  assign out_o.overflow    = ovf_q;

  // a pending result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_o.valid |-> !in_i.ready)
    else $error("input taken while a result is pending");

  // buffer fill never passes its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(ROW_MAX))
    else $error("row count beyond buffer depth");

  // a row that ends always has at least one buffered element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_EXP_RD) |=> count_q != '0)
    else $error("row ended with an empty buffer");

  // results leave only from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_o.valid |-> state_q == S_OUT)
    else $error("result valid outside the output state");

endmodule

### verif/row_softmax_quantized_tb.sv
`timescale 1ns / 1ps
// Self-checking row softmax bench: directed, overflow, scale extremes, random, back-pressure.
module row_softmax_quantized_tb;
  import rsq_pkg::*;

  localparam int ROWS_DEPTH  = 64;
  localparam int IDLE_LIMIT  = 20000;  // cycles with no transaction before giving up
  localparam int DRAIN_GAP   = 40;     // settle time before a register write
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              last_of_row;
    logic              overflow;
  } prob_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_INV_IN_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rsq_in_if #(.VALUE_WIDTH(16)) in_if ();
  rsq_out_if                    out_if ();

  row_softmax_quantized #(.ROW_MAX(ROWS_DEPTH), .VALUE_WIDTH(16)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the block's row state and scale registers.
  int              row_vals [ROWS_DEPTH];
  int              row_cnt;
  int              row_peak;
  bit              row_dropped;
  longint unsigned inv_scale;
  longint unsigned full_scale;

  prob_result_t pending_probs [$];

  int err_count;
  int idle_cycles;
  int send_gap_pct;
  int stall_pct;
  int hold_cycles;
  int items_sent;

  // exp(-j/256) in Q40, 24-term series with positive and negative sums kept apart
  function automatic longint unsigned frac_exp(longint unsigned j);
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    pos  = 64'd1 << 40;
    neg  = 0;
    term = pos;
    for (int n = 1; n <= 24; n++) begin
      term = (term * j) / (256 * n);
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    return pos - neg;
  endfunction

  function automatic longint unsigned q40_product(longint unsigned a, longint unsigned b);
    longint unsigned hi;
    longint unsigned lo;
    hi = b >> 20;
    lo = b & 64'hFFFFF;
    return ((a * hi) + ((a * lo) >> 20)) >> 20;
  endfunction

  // Q15 exponential of a distance m in 1/256 steps, zero past a distance of 16
  function automatic int unsigned q15_exp(longint unsigned m);
    longint unsigned v;
    longint unsigned e1;
    if (m > 4096) return 0;
    v  = frac_exp(m & 255);
    e1 = frac_exp(256);
    for (longint unsigned i = 0; i < (m >> 8); i++) v = q40_product(v, e1);
    return int'((v + (64'd1 << 24)) >> 25);
  endfunction

  function automatic void clear_row_model();
    row_cnt     = 0;
    row_peak    = -32768;
    row_dropped = 1'b0;
  endfunction

  // Fold one accepted element into the row; on row end queue every probability.
  function automatic void absorb_element(logic signed [15:0] v, bit last);
    int unsigned     exps [ROWS_DEPTH];
    longint unsigned total;
    longint unsigned t;
    longint unsigned num;
    longint unsigned den;
    prob_result_t    r;
    if (row_cnt < ROWS_DEPTH) begin
      row_vals[row_cnt] = v;
      if (int'(v) > row_peak) row_peak = v;
      row_cnt++;
    end else begin
      row_dropped = 1'b1;
    end
    if (!last) return;
    total = 0;
    for (int i = 0; i < row_cnt; i++) begin
      t       = longint'(row_peak - row_vals[i]);
      exps[i] = q15_exp((t * inv_scale) >> 4);
      total  += exps[i];
    end
    for (int i = 0; i < row_cnt; i++) begin
      num           = 2 * full_scale * exps[i] + total;
      den           = 2 * total;
      r.prob        = PROB_W'(den != 0 ? num / den : 0);
      r.last_of_row = (i + 1 == row_cnt);
      r.overflow    = row_dropped;
      pending_probs.push_back(r);
    end
    clear_row_model();
  endfunction

  // Offer one element, with random idle cycles ahead of it; hold valid until accepted.
  task automatic push_element(logic signed [15:0] v, bit last);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.value   <= v;
    in_if.row_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_element(v, last);
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Write one register once every pending result has drained and the block has settled.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    drop_valid();
    while (pending_probs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_INV_IN_SCALE) inv_scale = data;
    else full_scale = data & 16'h7FFF;
  endtask

  task automatic set_scales(int unsigned inv, int unsigned osc);
    write_reg(CFG_INV_IN_SCALE, CFG_DATA_W'(inv));
    write_reg(CFG_OUT_SCALE, CFG_DATA_W'(osc));
  endtask

  task automatic send_row(int len, int base, int spread);
    for (int i = 0; i < len; i++)
      push_element(16'(base + int'($urandom_range(spread))), i == len - 1);
  endtask

  // Mostly short rows of nearby values; now and then full-range values or an overlong row.
  task automatic send_random_row();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(8, 1);
    else if (pick < 95) len = $urandom_range(64, 9);
    else len = $urandom_range(70, 65);
    case ($urandom_range(2))
      0: send_row(len, int'($urandom_range(65535)) - 32768, 15);
      1: send_row(len, int'($urandom_range(65535)) - 32768, 255);
      default: send_row(len, 0, 65535);
    endcase
  endtask

  task automatic test_directed_rows();
    push_element(16'sd5, 1'b1);                       // single-element row
    push_element(-16'sd32768, 1'b0);                  // widest distance
    push_element(16'sd32767, 1'b1);
    push_element(16'sd100, 1'b0);                     // equal weights
    push_element(16'sd100, 1'b0);
    push_element(16'sd100, 1'b1);
    push_element(16'sd0, 1'b0);                       // distance at and past the zero cutoff
    push_element(-16'sd15, 1'b0);
    push_element(-16'sd17, 1'b0);
    push_element(16'sd1, 1'b1);
  endtask

  // Overlong row: the surplus is dropped, and the row end lands on a dropped element.
  task automatic test_row_overflow();
    for (int i = 0; i < ROWS_DEPTH + 2; i++)
      push_element(16'($urandom_range(40)) - 16'sd20, i == ROWS_DEPTH + 1);
    push_element(16'sd7, 1'b1);                       // next row starts clean
  endtask

  task automatic test_scale_extremes();
    set_scales(65535, 32767);
    push_element(16'sd0, 1'b0);
    push_element(16'sd1, 1'b0);
    push_element(-16'sd2, 1'b1);
    set_scales(0, 0);                                 // zero scales: equal weights, zero output
    push_element(-16'sd32768, 1'b0);
    push_element(16'sd32767, 1'b1);
    set_scales(0, 32767);
    push_element(16'sd3, 1'b0);
    push_element(-16'sd300, 1'b1);
    set_scales(1, 1);
    push_element(16'sd32767, 1'b0);
    push_element(-16'sd32768, 1'b1);
  endtask

  task automatic test_random_rows();
    int quota;
    int gaps [4]   = '{0, 46, 0, 18};
    int stalls [4] = '{0, 0, 46, 18};
    quota = items_sent + RANDOM_ITEMS;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) set_scales($urandom_range(65535, 1), $urandom_range(32767, 1));
      else if (ph != 0) set_scales($urandom_range(8192, 256), $urandom_range(255, 1));
      send_gap_pct = gaps[ph];
      stall_pct    = stalls[ph];
      while (items_sent < quota - (3 - ph) * RANDOM_ITEMS / 4) send_random_row();
    end
  endtask

  // Hold off the receiver while the next row keeps being offered, so the block backs up.
  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct    = 10;
    drop_valid();
    hold_cycles = 600;
    send_row(ROWS_DEPTH, -1000, 2000);
    send_row(5, 100, 3);
  endtask

  // Receiver: random stalls, or a hold-off counted in cycles with a result waiting.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      if (out_if.valid) hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin
    prob_result_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_probs.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t unexpected result prob=%0d last=%0b ovf=%0b", $realtime,
                     out_if.prob, out_if.last_of_row, out_if.overflow);
        end else begin
          want = pending_probs.pop_front();
          if (want.prob !== out_if.prob || want.last_of_row !== out_if.last_of_row ||
              want.overflow !== out_if.overflow) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t mismatch: expected prob=%0d last=%0b ovf=%0b, got %0d %0b %0b",
                       $realtime, want.prob, want.last_of_row, want.overflow,
                       out_if.prob, out_if.last_of_row, out_if.overflow);
          end
        end
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.value   = '0;
    in_if.row_end = 1'b0;
    out_if.ready  = 1'b0;
    err_count     = 0;
    idle_cycles   = 0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    items_sent    = 0;
    inv_scale     = INV_RESET;
    full_scale    = OSC_RESET;
    clear_row_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_rows();
    test_row_overflow();
    test_scale_extremes();
    test_random_rows();
    test_backpressure();

    drop_valid();
    while (pending_probs.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && pending_probs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
